FILE: rtl/abpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and helpers of the atom bond pair detector.
// No dependencies; imported by the detector, distance pipeline and checker.
package abpd_pkg;

	// store depth and derived index widths
	localparam int MAX_ATOMS = 64;
	localparam int ADDR_W    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int CNT_W     = $clog2(MAX_ATOMS + 1);

	// field widths of one atom
	localparam int ID_W  = 16;
	localparam int POS_W = 19;
	localparam int RAD_W = 10;

	// arithmetic widths: |a-b| of two POS_W values fits in POS_W unsigned bits
	localparam int SQ_W   = 2 * POS_W;
	localparam int D2_W   = SQ_W + 2;
	localparam int TEST_W = D2_W + 2;
	localparam int RS_W   = RAD_W + 1;
	localparam int RS2_W  = 2 * RS_W;

	// one atom as it travels on the input stream and sits in the store
	typedef struct packed {
		logic [RAD_W-1:0] radius;
		logic [POS_W-1:0] pos_z;
		logic [POS_W-1:0] pos_y;
		logic [POS_W-1:0] pos_x;
		logic [ID_W-1:0]  atom_id;
	} atom_t;

	localparam int ATOM_W     = $bits(atom_t);
	localparam int IN_DATA_W  = ((ATOM_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = 2 * ID_W;

	// result of one comparison leaving the distance pipeline
	typedef struct packed {
		logic            valid;
		logic            last;
		logic            hit;
		logic [ID_W-1:0] id;
	} cmp_res_t;

	// magnitude of the difference of two signed coordinates
	function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
			input logic [POS_W-1:0] b);
		logic [POS_W:0] d;
		logic [POS_W:0] n;
		d = {a[POS_W-1], a} - {b[POS_W-1], b};
		n = -d;
		return d[POS_W] ? n[POS_W-1:0] : d[POS_W-1:0];
	endfunction

endpackage

FILE: rtl/abpd_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module abpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/abpd_dist.sv
`timescale 1ns / 1ps
// Distance test pipeline: compares the current atom with one stored atom per
// cycle while adv is high, 4*d^2 <= (ri+rj)^2. Depends on abpd_pkg.
module abpd_dist import abpd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     in_valid,
	input  logic     in_last,
	input  atom_t    cur,
	input  atom_t    stored,
	output cmp_res_t res,
	output logic     busy
);

	logic [POS_W-1:0] mag_x_s2, mag_y_s2, mag_z_s2;
	logic [RS_W-1:0]  rs_s2;
	logic [ID_W-1:0]  id_s2;
	logic             v_s2, last_s2;

	logic [SQ_W-1:0]  sq_x_s3, sq_y_s3, sq_z_s3;
	logic [RS2_W-1:0] rs2_s3;
	logic [ID_W-1:0]  id_s3;
	logic             v_s3, last_s3;

	logic [D2_W-1:0]   d2;
	logic [TEST_W-1:0] lhs;

	// valid and last tags follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			v_s3    <= 1'b0;
			last_s3 <= 1'b0;
		end else if (adv) begin
			v_s2    <= in_valid;
			last_s2 <= in_last;
			v_s3    <= v_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 2: coordinate difference magnitudes and radius sum
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_x_s2 <= abs_diff(cur.pos_x, stored.pos_x);
			mag_y_s2 <= abs_diff(cur.pos_y, stored.pos_y);
			mag_z_s2 <= abs_diff(cur.pos_z, stored.pos_z);
			rs_s2    <= {1'b0, cur.radius} + {1'b0, stored.radius};
			id_s2    <= stored.atom_id;
		end
	end

	// stage 3: squares
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_x_s3 <= mag_x_s2 * mag_x_s2;
			sq_y_s3 <= mag_y_s2 * mag_y_s2;
			sq_z_s3 <= mag_z_s2 * mag_z_s2;
			rs2_s3  <= rs_s2 * rs_s2;
			id_s3   <= id_s2;
		end
	end

	// sum of squares and bond test
	assign d2  = D2_W'(sq_x_s3) + D2_W'(sq_y_s3) + D2_W'(sq_z_s3);
	assign lhs = {d2, 2'b00};

	always_comb begin
		res.valid = v_s3;
		res.last  = last_s3;
		res.hit   = (lhs <= TEST_W'(rs2_s3));
		res.id    = id_s3;
	end

	assign busy = v_s2 | v_s3;

endmodule

FILE: rtl/atom_bond_pair_detector.sv
`timescale 1ns / 1ps
// Atom bond pair detector top level: atom store, scan control, bond output.
// Depends on abpd_pkg, abpd_ram and abpd_dist.
//
// Atoms enter on the s_ stream, one transaction per atom; s_tuser set starts
// a new model and empties the store first. Each atom is compared with every
// stored atom of the model, lowest store entry first, and then kept in the
// store. Every bond leaves on the m_ stream as the stored atom's id and the
// new atom's id; m_tlast marks the last bond of that atom. An atom with no
// bond gives no transaction; atoms past MAX_ATOMS in one model are dropped.
// An atom is written to the store in the cycle it is accepted. The scan then
// reads one stored atom per cycle from the store RAM while the output can
// take bonds, so an atom with stored predecessors keeps s_tready low until
// its scan and held bond have left the pipeline; with none stored s_tready
// stays high. The first bond shows on m_tvalid only after the entry it matches
// has passed the distance pipeline, since one bond is held back until the next
// is found or the scan ends.
// When m_tready is low with a bond waiting, the whole scan freezes until it is
// taken. The final bond of an atom may still wait in the output register while
// the next atom is accepted. Reset empties the store and drops work in flight.
module atom_bond_pair_detector import abpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// atom_id, pos_x, pos_y, pos_z, radius, zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// first_of_model
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// first_atom_id, second_atom_id
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	atom_t            in_atom;
	atom_t            cur_q;
	atom_t            rd_atom;
	cmp_res_t         res;
	logic             accept_in, store_en, full, adv, busy, pipe_busy;
	logic [CNT_W-1:0] count_q, cnt_eff, scan_n_q, rd_k_q;
	logic             scan_q, scan_last, v_s1, last_s1;
	logic             pend_v_q, flush_q;
	logic [ID_W-1:0]  pend_id_q;
	logic             emit_mid, emit_end, load;
	logic             out_v_q, out_last_q;
	logic [ID_W-1:0]  out_first_q, out_second_q;

	// input transaction and store fill
	assign in_atom   = s_tdata[ATOM_W-1:0];
	assign accept_in = s_tvalid && s_tready;
	assign cnt_eff   = s_tuser ? '0 : count_q;
	assign full      = (cnt_eff == CNT_W'(MAX_ATOMS));
	assign store_en  = accept_in && !full;

	// pipeline moves whenever the output register can take a bond
	assign adv       = !out_v_q || m_tready;
	assign scan_last = (rd_k_q == scan_n_q - CNT_W'(1));

	abpd_ram #(
		.WIDTH (ATOM_W),
		.DEPTH (MAX_ATOMS)
	) u_store (
		.clk     (clk),
		.wr_en   (store_en),
		.wr_addr (cnt_eff[ADDR_W-1:0]),
		.wr_data (in_atom),
		.rd_en   (adv),
		.rd_addr (rd_k_q[ADDR_W-1:0]),
		.rd_data (rd_atom)
	);

	// atom count and scan sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			scan_n_q <= '0;
			rd_k_q   <= '0;
			scan_q   <= 1'b0;
			v_s1     <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			if (accept_in) begin
				count_q  <= store_en ? cnt_eff + CNT_W'(1) : cnt_eff;
				scan_n_q <= cnt_eff;
				rd_k_q   <= '0;
				scan_q   <= store_en && (cnt_eff != '0);
			end else if (adv && scan_q) begin
				rd_k_q <= rd_k_q + CNT_W'(1);
				if (scan_last) begin
					scan_q <= 1'b0;
				end
			end
			if (adv) begin
				v_s1    <= scan_q;
				last_s1 <= scan_q && scan_last;
			end
		end
	end

	// current atom held for the whole scan
	always_ff @(posedge clk) begin
		if (store_en) begin
			cur_q <= in_atom;
		end
	end

	abpd_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (v_s1),
		.in_last  (last_s1),
		.cur      (cur_q),
		.stored   (rd_atom),
		.res      (res),
		.busy     (pipe_busy)
	);

	// one bond held back so the last one of an atom can be marked
	assign emit_mid = res.valid && res.hit && pend_v_q;
	assign emit_end = flush_q && pend_v_q;
	assign load     = emit_mid || emit_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			flush_q  <= 1'b0;
			out_v_q  <= 1'b0;
		end else if (adv) begin
			if (res.valid && res.hit) begin
				pend_v_q <= 1'b1;
			end else if (emit_end) begin
				pend_v_q <= 1'b0;
			end
			flush_q <= res.valid && res.last;
			out_v_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid && res.hit) begin
			pend_id_q <= res.id;
		end
		if (adv && load) begin
			out_first_q  <= pend_id_q;
			out_second_q <= cur_q.atom_id;
			out_last_q   <= emit_end;
		end
	end

	// handshake outputs
	assign busy     = scan_q | v_s1 | pipe_busy | pend_v_q | flush_q;
	assign s_tready = !busy;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_second_q, out_first_q};
	assign m_tlast  = out_last_q;

endmodule

FILE: rtl/abpd_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the atom bond pair detector and their bind.
// Depends on abpd_pkg and the atom_bond_pair_detector top level.
module abpd_checker import abpd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	// a stalled bond holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("bond changed while stalled");

	// a bond on the output never carries unknown bits
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !$isunknown({m_tdata, m_tlast}))
		else $error("unknown bits in a bond transaction");

	// while idle only the final bond of an atom can still wait
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && m_tvalid |-> m_tlast)
		else $error("non-final bond waiting while input ready");

endmodule

bind atom_bond_pair_detector abpd_checker u_abpd_checker (.*);
